FILE: sv/cfc_pkg.sv
// shared types and constants for the per-flow cork coalescer
// no dependencies; the other files that use it refer to this package by scoped names
package cfc_pkg;

	localparam int FLOW_ENTRIES = 512;
	localparam int IDX_W = $clog2(FLOW_ENTRIES);

	// divide-by-ten unit: floor(d / 10) = (d * DIV10_RECIP) >> DIV10_SHIFT for 32-bit d
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int DIV10_SHIFT = 35;

	localparam int LIMIT_BIT = 9;
	localparam int LAST_READER = 8;

	typedef enum logic [1:0] {
		OP_NODELAY = 2'd0,
		OP_SEND    = 2'd1,
		OP_RECV    = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_CORK  = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;
	localparam logic [1:0] ACT_STAT  = 2'd3;

	localparam logic [1:0] SK_LAT  = 2'd0;
	localparam logic [1:0] SK_QLEN = 2'd1;
	localparam logic [1:0] SK_SIZE = 2'd2;

	localparam logic REG_MAX_QLEN = 1'b0;
	localparam logic REG_STATS_EN = 1'b1;

	typedef struct packed {
		logic [31:0] n;
		logic [31:0] avg;
		logic [31:0] mn;
		logic [31:0] mx;
	} stat32_t;

	typedef struct packed {
		logic [31:0] n;
		logic [15:0] avg;
		logic [15:0] mn;
		logic [15:0] mx;
	} stat16_t;

	typedef struct packed {
		logic        corking;
		logic [15:0] pending;
		logic [31:0] cork_start;
		logic [9:0]  mask;
		stat32_t     lat;
		stat16_t     qlen;
		stat32_t     size;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic eval;
		logic sample;
		logic write;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic samp_left;
		logic div_busy;
		logic emit_last;
	} sts_t;

endpackage

FILE: sv/cfc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module cfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/cfc_div10.sv
// (9*avg + sample) / 10 by reciprocal multiplication
// depends on cfc_pkg
module cfc_div10 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] avg,
	input  logic [31:0] sample,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient
);

	logic [1:0]  ph_q;
	logic        busy_q;
	logic        done_q;
	logic        up_q;
	logic [31:0] base_q;
	logic [31:0] diff_q;
	logic [63:0] prod_q;
	logic [31:0] quot_q;
	logic [28:0] tenth;

	// 9*avg + sample = 10*avg + (sample - avg)
	assign tenth = prod_q[63:cfc_pkg::DIV10_SHIFT];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			ph_q <= {ph_q[0], start};
			if (start) begin
				busy_q <= 1'b1;
			end else if (ph_q[1]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// difference, reciprocal multiply, final correction
	always_ff @(posedge clk) begin
		if (start) begin
			up_q <= sample >= avg;
			base_q <= avg;
			diff_q <= (sample >= avg) ? sample - avg : avg - sample - 32'd1;
		end
		if (ph_q[0]) begin
			prod_q <= 64'(diff_q) * 64'(cfc_pkg::DIV10_RECIP);
		end
		if (ph_q[1]) begin
			quot_q <= up_q ? base_q + 32'(tenth) : base_q - 32'(tenth) - 32'd1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quot_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done longer than one cycle");

endmodule

FILE: sv/cfc_datapath.sv
// flow table, item registers, entry update, statistic update and result registers
// depends on cfc_pkg, cfc_ram, cfc_div10
module cfc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cfc_pkg::cmd_t       cmd,
	output cfc_pkg::sts_t       sts,
	input  logic [1:0]          op,
	input  logic [8:0]          flow,
	input  logic                nodelay_on,
	input  logic [31:0]         send_length,
	input  logic [31:0]         now_us,
	input  logic [3:0]          reader_kind,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                strobe,
	output logic [1:0]          action,
	output logic [8:0]          flow_out,
	output logic [1:0]          stat_kind,
	output logic [31:0]         samples,
	output logic [31:0]         average,
	output logic [31:0]         minimum,
	output logic [31:0]         maximum,
	output logic [9:0]          flusher_mask,
	output logic                last
);

	logic [15:0] max_qlen_q;
	logic        stats_en_q;

	logic [cfc_pkg::IDX_W-1:0] idx_q;
	logic [cfc_pkg::IDX_W-1:0] clr_q;
	cfc_pkg::op_t              op_q;
	logic [8:0]                flow_q;
	logic                      on_q;
	logic [31:0]               len_q;
	logic [31:0]               now_q;
	logic [3:0]                kind_q;

	cfc_pkg::entry_t ent_q;
	cfc_pkg::entry_t rd_ent;
	cfc_pkg::entry_t ev;
	logic [cfc_pkg::ENTRY_W-1:0] rdata;

	logic [2:0]  samp_q;
	logic [31:0] lat_v_q;
	logic [15:0] qlen_v_q;
	logic        asserted_q;
	logic        flushed_q;
	logic [1:0]  emit_q;
	logic [1:0]  div_idx_q;

	logic        ev_asrt;
	logic        ev_flush;
	logic        ev_size;
	logic [9:0]  ev_bit;
	logic [15:0] ev_p1;
	logic [31:0] ev_lat;
	logic [15:0] ev_qlen;

	logic [1:0]                  sel;
	cfc_pkg::stat32_t            cur;
	cfc_pkg::stat32_t            nxt;
	logic [31:0]                 sval;
	logic                        need_div;
	logic                        div_busy;
	logic                        div_done;
	logic [31:0]                 quotient;

	logic [1:0]       res_action;
	logic [1:0]       last_idx;
	cfc_pkg::stat32_t res_stat;

	logic                        ram_we;
	logic [cfc_pkg::IDX_W-1:0]   ram_waddr;
	logic [cfc_pkg::ENTRY_W-1:0] ram_wdata;

	// configuration registers, written at any transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_qlen_q <= '0;
			stats_en_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				cfc_pkg::REG_MAX_QLEN: max_qlen_q <= cfg_data;
				cfc_pkg::REG_STATS_EN: stats_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// flow table
	assign ram_we = cmd.clear | cmd.write;
	assign ram_waddr = cmd.clear ? clr_q : idx_q;
	assign ram_wdata = cmd.clear ? '0 : ent_q;

	cfc_ram #(
		.WIDTH(cfc_pkg::ENTRY_W),
		.DEPTH(cfc_pkg::FLOW_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (cfc_pkg::IDX_W'(flow % cfc_pkg::FLOW_ENTRIES)),
		.rdata (rdata)
	);

	assign rd_ent = cfc_pkg::entry_t'(rdata);

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q <= cfc_pkg::IDX_W'(flow % cfc_pkg::FLOW_ENTRIES);
			op_q <= cfc_pkg::op_t'(op);
			flow_q <= flow;
			on_q <= nodelay_on;
			len_q <= send_length;
			now_q <= now_us;
			kind_q <= reader_kind;
		end
	end

	// per-op entry update ahead of the statistics
	always_comb begin
		ev = rd_ent;
		ev_asrt = 1'b0;
		ev_flush = 1'b0;
		ev_size = 1'b0;
		ev_bit = '0;
		ev_p1 = rd_ent.pending + 16'd1;
		case (op_q)
			cfc_pkg::OP_NODELAY: begin
				if (on_q) begin
					if (!ev.corking) begin
						ev.corking = 1'b1;
						ev.pending = '0;
					end
				end else if (ev.corking) begin
					ev.corking = 1'b0;
					ev.pending = '0;
				end
			end
			cfc_pkg::OP_SEND: begin
				if (ev.corking) begin
					if (ev.pending == '0) begin
						ev.cork_start = now_q;
						ev_asrt = 1'b1;
					end
					ev.pending = ev_p1;
					ev_size = 1'b1;
					if (max_qlen_q != '0 && ev_p1 >= max_qlen_q) begin
						ev_flush = 1'b1;
						ev_bit = 10'(1) << cfc_pkg::LIMIT_BIT;
					end
				end
			end
			cfc_pkg::OP_RECV: begin
				if (ev.pending != '0) begin
					ev_flush = 1'b1;
					if (kind_q <= 4'(cfc_pkg::LAST_READER)) begin
						ev_bit = 10'(1) << kind_q;
					end
				end
			end
			default: ;
		endcase
		ev_lat = now_q - ev.cork_start;
		ev_qlen = ev.pending;
		if (ev_flush) begin
			if (stats_en_q) begin
				ev.mask = ev.mask | ev_bit;
			end
			ev.pending = '0;
		end
	end

	// pick the lowest pending statistic and view it at 32 bits
	always_comb begin
		if (samp_q[0]) begin
			sel = cfc_pkg::SK_LAT;
		end else if (samp_q[1]) begin
			sel = cfc_pkg::SK_QLEN;
		end else begin
			sel = cfc_pkg::SK_SIZE;
		end
		case (sel)
			cfc_pkg::SK_LAT: begin
				cur = ent_q.lat;
				sval = lat_v_q;
			end
			cfc_pkg::SK_QLEN: begin
				cur.n = ent_q.qlen.n;
				cur.avg = {16'd0, ent_q.qlen.avg};
				cur.mn = {16'd0, ent_q.qlen.mn};
				cur.mx = {16'd0, ent_q.qlen.mx};
				sval = {16'd0, qlen_v_q};
			end
			default: begin
				cur = ent_q.size;
				sval = len_q;
			end
		endcase
	end

	// sample update; the average goes through the divider when both old values are nonzero
	always_comb begin
		nxt = cur;
		need_div = 1'b0;
		nxt.n = cur.n + 32'd1;
		if (cur.n == '0) begin
			nxt.avg = sval;
			nxt.mn = sval;
			nxt.mx = sval;
		end else begin
			if (cur.avg == '0) begin
				nxt.avg = sval;
			end else begin
				need_div = 1'b1;
			end
			if (sval > cur.mx) begin
				nxt.mx = sval;
			end
			if (sval < cur.mn) begin
				nxt.mn = sval;
			end
		end
	end

	cfc_div10 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sample & need_div),
		.avg      (cur.avg),
		.sample   (sval),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	// entry register and statistic bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			ent_q <= ev;
			lat_v_q <= ev_lat;
			qlen_v_q <= ev_qlen;
			asserted_q <= ev_asrt;
			flushed_q <= ev_flush;
		end else if (cmd.sample) begin
			div_idx_q <= sel;
			case (sel)
				cfc_pkg::SK_LAT: ent_q.lat <= nxt;
				cfc_pkg::SK_QLEN: begin
					ent_q.qlen.n <= nxt.n;
					ent_q.qlen.avg <= nxt.avg[15:0];
					ent_q.qlen.mn <= nxt.mn[15:0];
					ent_q.qlen.mx <= nxt.mx[15:0];
				end
				default: ent_q.size <= nxt;
			endcase
		end else if (div_done) begin
			case (div_idx_q)
				cfc_pkg::SK_LAT: ent_q.lat.avg <= quotient;
				cfc_pkg::SK_QLEN: ent_q.qlen.avg <= quotient[15:0];
				default: ent_q.size.avg <= quotient;
			endcase
		end
	end

	// statistics still to take and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_q <= '0;
			emit_q <= '0;
		end else begin
			if (cmd.eval) begin
				samp_q <= {ev_size, ev_flush & stats_en_q, ev_flush & stats_en_q};
				emit_q <= '0;
			end else if (cmd.sample) begin
				samp_q[sel] <= 1'b0;
			end
			if (cmd.emit) begin
				emit_q <= emit_q + 2'd1;
			end
		end
	end

	// result selection
	always_comb begin
		res_stat = '0;
		last_idx = 2'd0;
		case (op_q)
			cfc_pkg::OP_NODELAY: res_action = on_q ? cfc_pkg::ACT_CORK : cfc_pkg::ACT_FLUSH;
			cfc_pkg::OP_SEND: begin
				if (asserted_q && flushed_q) begin
					last_idx = 2'd1;
				end
				if (emit_q != 2'd0) begin
					res_action = cfc_pkg::ACT_FLUSH;
				end else if (asserted_q) begin
					res_action = cfc_pkg::ACT_CORK;
				end else if (flushed_q) begin
					res_action = cfc_pkg::ACT_FLUSH;
				end else begin
					res_action = cfc_pkg::ACT_NONE;
				end
			end
			cfc_pkg::OP_RECV: res_action = flushed_q ? cfc_pkg::ACT_FLUSH : cfc_pkg::ACT_NONE;
			default: begin
				res_action = cfc_pkg::ACT_STAT;
				last_idx = 2'd2;
				case (emit_q)
					cfc_pkg::SK_LAT: res_stat = ent_q.lat;
					cfc_pkg::SK_QLEN: begin
						res_stat.n = ent_q.qlen.n;
						res_stat.avg = {16'd0, ent_q.qlen.avg};
						res_stat.mn = {16'd0, ent_q.qlen.mn};
						res_stat.mx = {16'd0, ent_q.qlen.mx};
					end
					default: res_stat = ent_q.size;
				endcase
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			action <= res_action;
			flow_out <= flow_q;
			stat_kind <= (op_q == cfc_pkg::OP_QUERY) ? emit_q : cfc_pkg::SK_LAT;
			samples <= res_stat.n;
			average <= res_stat.avg;
			minimum <= res_stat.mn;
			maximum <= res_stat.mx;
			flusher_mask <= ent_q.mask;
			last <= emit_q == last_idx;
		end
	end

	assign sts.clr_done = clr_q == cfc_pkg::IDX_W'(cfc_pkg::FLOW_ENTRIES - 1);
	assign sts.samp_left = samp_q != '0;
	assign sts.div_busy = div_busy | div_done;
	assign sts.emit_last = emit_q == last_idx;

	a_sample_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sample |-> (samp_q != '0) && !div_busy)
		else $error("sample step with nothing to take or divider running");
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("result burst broken before its last transfer");
	a_emit_after_stats: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (samp_q == '0) && !div_busy && !div_done)
		else $error("result sent before statistics settled");

endmodule

FILE: sv/cfc_ctrl.sv
// controller state machine: clearing sweep, item sequencing, result burst
// depends on cfc_pkg
module cfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output cfc_pkg::cmd_t cmd,
	input  cfc_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_SAMPLE,
		ST_DIVW,
		ST_WRITE,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d = ST_SAMPLE;
			end
			ST_SAMPLE: begin
				if (sts.samp_left) begin
					cmd.sample = 1'b1;
					state_d = ST_DIVW;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_DIVW: begin
				if (!sts.div_busy) begin
					state_d = ST_SAMPLE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q <= state_d != ST_IDLE;
		end
	end

	assign busy = busy_q;

	a_busy_matches: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE))
		else $error("busy out of step with state");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> busy_q && state_q == ST_EVAL)
		else $error("accepted item not taken up");
	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> cmd.emit)
		else $error("write-back not followed by results");

endmodule

FILE: sv/per_flow_cork_coalescer_core.sv
// top level of the per-flow cork coalescer: controller plus datapath
// depends on cfc_pkg, cfc_ctrl, cfc_datapath (with cfc_ram, cfc_div10)
//
// channel   handshake                 payload
// -------   ---------                 -------
// item      start / busy              op flow nodelay_on send_length now_us reader_kind
// result    strobe (no stall)         action flow_out stat_kind samples average
//                                     minimum maximum flusher_mask last
// config    cfg_valid / cfg_ready     cfg_index cfg_data
//
// an item passes through evaluation, one sampling step per statistic sampled,
// a wait on the divide-by-ten for each sampled average that needs it (up to
// three per item), write-back and its results; statistics update one at a time
// after reset the flow table is cleared one entry a cycle, all FLOW_ENTRIES entries,
// with busy high; configuration transfers are taken during that time too
// results come out as a burst on consecutive cycles and cannot be held off
module per_flow_cork_coalescer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [8:0]  flow,
	input  logic        nodelay_on,
	input  logic [31:0] send_length,
	input  logic [31:0] now_us,
	input  logic [3:0]  reader_kind,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output logic [1:0]  action,
	output logic [8:0]  flow_out,
	output logic [1:0]  stat_kind,
	output logic [31:0] samples,
	output logic [31:0] average,
	output logic [31:0] minimum,
	output logic [31:0] maximum,
	output logic [9:0]  flusher_mask,
	output logic        last
);

	cfc_pkg::cmd_t cmd;
	cfc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	cfc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.flow         (flow),
		.nodelay_on   (nodelay_on),
		.send_length  (send_length),
		.now_us       (now_us),
		.reader_kind  (reader_kind),
		.cfg_valid    (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.action       (action),
		.flow_out     (flow_out),
		.stat_kind    (stat_kind),
		.samples      (samples),
		.average      (average),
		.minimum      (minimum),
		.maximum      (maximum),
		.flusher_mask (flusher_mask),
		.last         (last)
	);

endmodule
